// ===== rtl/sorted_key_table_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted key table assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check that prop holds at every rising edge outside reset.
`define SKT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that expr is never true outside reset.
`define SKT_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SKT_ASSERT(lbl, clk, rst, prop, msg)
`define SKT_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared codes, field widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Stream field widths
  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int STS_W   = 2;
  localparam int TOTAL_W = 7;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_DONE = 2'd0,
    STS_FULL = 2'd1,
    STS_DUP  = 2'd2,
    STS_MISS = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_DECIDE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_FINISH
  } state_t;

  // Memory read address source
  typedef enum logic [1:0] {
    RD_MID,
    RD_LO,
    RD_BELOW,
    RD_ABOVE
  } rd_src_t;

  // Memory write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_NEW
  } wr_src_t;

  typedef struct packed {
    logic    take_req;
    logic    rd_en;
    rd_src_t rd_src;
    wr_src_t wr_src;
    logic    step;
    logic    probe;
    logic    cur_ld_ins;
    logic    cur_ld_del;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_status;
    status_t status;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic            search_done;
    logic            probe_ok;
    logic            full;
    logic            hit;
    logic [OP_W-1:0] op;
    logic            up_done;
    logic            dn_done;
    logic            out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/skt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted key table controller
// Sequences search, probe, entry moves and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire skt_pkg::sts_t sts,
  output skt_pkg::cmd_t      cmd
);

  import skt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    req_ready      = 1'b0;
    cmd            = '0;
    cmd.rd_src     = RD_MID;
    cmd.wr_src     = WR_NONE;
    cmd.status     = STS_DONE;

    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take_req = 1'b1;
          state_next   = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (sts.search_done) begin
          state_next = S_PROBE_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_MID;
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd.step   = 1'b1;
        state_next = S_SRCH_RD;
      end
      S_PROBE_RD: begin
        if (sts.probe_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_LO;
          state_next = S_PROBE_CMP;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_PROBE_CMP: begin
        cmd.probe  = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.set_status = 1'b1;
        state_next     = S_FINISH;
        unique case (op_t'(sts.op))
          OP_INSERT: begin
            if (sts.full) begin
              cmd.status = STS_FULL;
            end else if (sts.hit) begin
              cmd.status = STS_DUP;
            end else begin
              cmd.status     = STS_DONE;
              cmd.cur_ld_ins = 1'b1;
              state_next     = S_UP_RD;
            end
          end
          OP_DELETE: begin
            if (sts.hit) begin
              cmd.status     = STS_DONE;
              cmd.cur_ld_del = 1'b1;
              state_next     = S_DN_RD;
            end else begin
              cmd.status = STS_MISS;
            end
          end
          default: begin
            cmd.status = sts.hit ? STS_DONE : STS_MISS;
          end
        endcase
      end
      S_UP_RD: begin
        if (sts.up_done) begin
          cmd.wr_src  = WR_NEW;
          cmd.cnt_inc = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_BELOW;
          state_next = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.wr_src = WR_UP;
        state_next = S_UP_RD;
      end
      S_DN_RD: begin
        if (sts.dn_done) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_ABOVE;
          state_next = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd.wr_src = WR_DOWN;
        state_next = S_DN_RD;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/skt_dpath.sv =====
// ----------------------------------------------------------------------------
// Sorted key table datapath
// Entry memory, search bounds, move cursor, entry count and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_key_table_assert.svh"

module skt_dpath #(
  parameter int DEPTH       = skt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = skt_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = skt_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire skt_pkg::cmd_t                 cmd,
  output skt_pkg::sts_t                      sts,
  input  wire logic [skt_pkg::OP_W-1:0]      in_op,
  input  wire logic [skt_pkg::KEY_W-1:0]     in_key,
  input  wire logic [skt_pkg::VALUE_W-1:0]   in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               found,
  output logic [skt_pkg::VALUE_W-1:0]        value_out,
  output logic [skt_pkg::POS_W-1:0]          position,
  output logic [skt_pkg::STS_W-1:0]          status,
  output logic [skt_pkg::TOTAL_W-1:0]        entry_total
);

  import skt_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EW    = KEY_WIDTH + VALUE_WIDTH;

  logic [EW-1:0]          mem [DEPTH];
  logic [EW-1:0]          rd_data;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       lo;
  logic [CNT_W-1:0]       hi;
  logic [CNT_W-1:0]       cur;
  logic [OP_W-1:0]        req_op;
  logic [KEY_WIDTH-1:0]   req_key;
  logic [VALUE_WIDTH-1:0] req_val;
  logic                   hit;
  logic [VALUE_WIDTH-1:0] hit_val;
  status_t                res_status;

  logic [CNT_W:0]                   mid_sum;
  logic [CNT_W-1:0]                 mid;
  logic [CNT_W-1:0]                 cur_dec;
  logic [CNT_W-1:0]                 cur_inc;
  logic [KEY_WIDTH-1:0]             rd_key;
  logic [VALUE_WIDTH-1:0]           rd_val;
  logic [AW-1:0]                    rd_addr;
  logic [AW-1:0]                    wr_addr;
  logic [EW-1:0]                    wr_data;
  logic                             wr_en;
  logic [KEY_WIDTH+KEY_W-1:0]       key_ext;
  logic [VALUE_WIDTH+VALUE_W-1:0]   val_ext;
  logic [VALUE_W+VALUE_WIDTH-1:0]   hit_val_ext;
  logic [POS_W+CNT_W-1:0]           pos_ext;
  logic [TOTAL_W+CNT_W-1:0]         total_ext;

  // Fit the stream fields to the stored widths
  assign key_ext = {{KEY_WIDTH{1'b0}}, in_key};
  assign val_ext = {{VALUE_WIDTH{1'b0}}, in_value};

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CNT_W:1];
  assign cur_dec = cur - CNT_W'(1);
  assign cur_inc = cur + CNT_W'(1);
  assign rd_key  = rd_data[KEY_WIDTH-1:0];
  assign rd_val  = rd_data[EW-1:KEY_WIDTH];

  always_comb begin
    case (cmd.rd_src)
      RD_MID:   rd_addr = mid[AW-1:0];
      RD_LO:    rd_addr = lo[AW-1:0];
      RD_BELOW: rd_addr = cur_dec[AW-1:0];
      RD_ABOVE: rd_addr = cur_inc[AW-1:0];
      default:  rd_addr = mid[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cur[AW-1:0];
    wr_data = rd_data;
    case (cmd.wr_src)
      WR_NONE: wr_en = 1'b0;
      WR_NEW: begin
        wr_addr = lo[AW-1:0];
        wr_data = {req_val, req_key};
      end
      default: begin
        wr_addr = cur[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Request, search bounds, probe result and move cursor
  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      req_op  <= in_op;
      req_key <= key_ext[KEY_WIDTH-1:0];
      req_val <= val_ext[VALUE_WIDTH-1:0];
      lo      <= '0;
      hi      <= count;
      hit     <= 1'b0;
      hit_val <= '0;
    end else if (cmd.step) begin
      if (rd_key < req_key) begin
        lo <= mid + CNT_W'(1);
      end else begin
        hi <= mid;
      end
    end else if (cmd.probe) begin
      hit     <= (rd_key == req_key);
      hit_val <= rd_val;
    end
    if (cmd.cur_ld_ins) begin
      cur <= count;
    end else if (cmd.cur_ld_del) begin
      cur <= lo;
    end else if (cmd.wr_src == WR_UP) begin
      cur <= cur_dec;
    end else if (cmd.wr_src == WR_DOWN) begin
      cur <= cur_inc;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CNT_W'(1);
    end
  end

  // Result register
  assign hit_val_ext = {{VALUE_W{1'b0}}, hit_val};
  assign pos_ext     = {{POS_W{1'b0}}, lo};
  assign total_ext   = {{TOTAL_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found       <= hit;
      value_out   <= hit ? hit_val_ext[VALUE_W-1:0] : '0;
      position    <= hit ? pos_ext[POS_W-1:0] : '0;
      status      <= res_status;
      entry_total <= total_ext[TOTAL_W-1:0];
    end
  end

  always_comb begin
    sts             = '0;
    sts.search_done = (lo == hi);
    sts.probe_ok    = (lo < count);
    sts.full        = (count == CNT_W'(DEPTH));
    sts.hit         = hit;
    sts.op          = req_op;
    sts.up_done     = (cur == lo);
    sts.dn_done     = (cur_inc == count);
    sts.out_free    = !out_valid || out_ready;
  end

  `SKT_ASSERT(a_count_range, clk, rst, count <= CNT_W'(DEPTH), "entry count beyond depth")
  `SKT_ASSERT(a_bounds, clk, rst, cmd.step |-> (lo < hi && hi <= count), "search bounds broken")
  `SKT_ASSERT(a_inc_room, clk, rst, cmd.cnt_inc |-> count < CNT_W'(DEPTH), "insert into full table")
  `SKT_ASSERT(a_dec_nonempty, clk, rst, cmd.cnt_dec |-> (count != '0 && hit), "delete without hit")
  `SKT_ASSERT(a_load_sets_valid, clk, rst, cmd.load_out |=> out_valid, "result not presented")

endmodule

`default_nettype wire

// ===== rtl/sorted_key_table.sv =====
// A find runs a read and a compare per binary-search step, then the search end, the probe
// read and compare, the decision and the result load. An accepted insert then moves each
// entry up with a read and a write before writing the new entry; a delete hit likewise
// moves each entry above it down. Requests are handled one at a time: the next is taken
// only from the idle state after the result load, so a held result stalls the next request.
// Reset (synchronous, active high) empties the table and the result register; no memory clear.
// ----------------------------------------------------------------------------
// Sorted key table
// Key/value table in ascending key order with find, insert and delete.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table #(
  parameter int DEPTH       = skt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = skt_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = skt_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Request stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [1:0] operation, [33:2] key, [65:34] value_in, [71:66] zero
  input  wire logic [skt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // Result stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [0] found, [32:1] value_out, [38:33] position, [40:39] status,
  // [47:41] entry_total
  output logic [skt_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);

  import skt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [OP_W-1:0]    in_op;
  logic [KEY_W-1:0]   in_key;
  logic [VALUE_W-1:0] in_value;

  logic               found;
  logic [VALUE_W-1:0] value_out;
  logic [POS_W-1:0]   position;
  logic [STS_W-1:0]   status;
  logic [TOTAL_W-1:0] entry_total;

  // Unpack the request transaction
  assign in_op    = s_axis_tdata[OP_W-1:0];
  assign in_key   = s_axis_tdata[OP_W+KEY_W-1:OP_W];
  assign in_value = s_axis_tdata[OP_W+KEY_W+VALUE_W-1:OP_W+KEY_W];

  // Sequencer: one request from acceptance to result hand-off
  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Entry store, search bounds and result register
  skt_dpath #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_op),
    .in_key      (in_key),
    .in_value    (in_value),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .found       (found),
    .value_out   (value_out),
    .position    (position),
    .status      (status),
    .entry_total (entry_total)
  );

  // Pack the result transaction, first field lowest
  assign m_axis_tdata = {entry_total, status, position, value_out, found};

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Drives find, insert and delete requests into the table and checks every result against
// a behavioural copy of the table kept in this module, typed rows of the opening table
// against their own expectation. A short table of hand-picked requests comes first, then
// randomised phases: fill to capacity, drain, and mixed traffic aimed at stored keys and
// their neighbours. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;

  localparam int DEPTH           = DEPTH_DEF;
  localparam int ITEM_TARGET     = 1200;  // requests offered before the stimulus stops
  localparam int QUIET_ITEMS     = 150;   // final stretch run without idling
  localparam int LONG_HOLD_AT    = 400;   // request count that starts the long result hold
  localparam int LONG_HOLD_LEN   = 300;   // cycles the result side holds off
  localparam int SETTLE_AT       = 800;   // request count that starts the settling pause
  localparam int TAIL_CYCLES     = 200;   // beyond the slowest request (full-table shift)
  localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no transaction on either side
  localparam int MAX_REPORTS     = 10;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unassigned code, behaves as a find

  // One result transaction, unpacked into its fields
  typedef struct packed {
    logic                found;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    position;
    status_t             status;
    logic [TOTAL_W-1:0]  total;
  } table_reply_t;

  // One row of the directed request table; want is used only where typed is set
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               typed;
    table_reply_t       want;
  } request_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [1:0] operation, [33:2] key, [65:34] value_in, [71:66] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [0] found, [32:1] value_out, [38:33] position, [40:39] status, [47:41] entry_total
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Behavioural copy of the table, advanced once per accepted request
  logic [KEY_W-1:0]   table_keys [DEPTH];
  logic [VALUE_W-1:0] table_vals [DEPTH];
  int                 entry_count = 0;

  table_reply_t       pending_replies [$];
  int                 requests_sent = 0;
  int                 mismatches = 0;
  int                 idle_cycles = 0;
  int                 stall_left = 0;
  bit                 long_hold_done = 1'b0;
  logic               quiet;

  assign quiet = (requests_sent >= ITEM_TARGET - QUIET_ITEMS);

  sorted_key_table i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hand-picked opening: empty table, extreme keys and values, duplicates,
  // the spare operation code, misses either side of a stored key, and shifts
  // at the front and back of the table.
  localparam request_row_t OPENING [25] = '{
    '{OP_FIND,   32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 6'd0, STS_MISS, 7'd0}},
    '{OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 6'd0, STS_MISS, 7'd0}},
    '{OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 6'd0, STS_DONE, 7'd1}},
    '{OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 6'd0, STS_DONE, 7'd2}},
    '{OP_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 6'd0, STS_DUP, 7'd2}},
    '{OP_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 6'd1, STS_DONE, 7'd2}},
    '{OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 1'b1, '{1'b0, 32'h0, 6'd0, STS_DONE, 7'd3}},
    '{OP_FIND,   32'h8000_0000, 32'h0000_0000, 1'b1,
      '{1'b1, 32'hA5A5_A5A5, 6'd1, STS_DONE, 7'd3}},
    '{OP_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 6'd2, STS_DONE, 7'd3}},
    '{OP_SPARE,  32'h0000_0007, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 6'd0, STS_MISS, 7'd3}},
    '{OP_FIND,   32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 6'd0, STS_MISS, 7'd3}},
    '{OP_FIND,   32'h8000_0001, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 6'd0, STS_MISS, 7'd3}},
    '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 6'd0, STS_DONE, 7'd2}},
    '{OP_FIND,   32'h8000_0000, 32'h0000_0000, 1'b1,
      '{1'b1, 32'hA5A5_A5A5, 6'd0, STS_DONE, 7'd2}},
    '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 6'd0, STS_MISS, 7'd2}},
    '{OP_INSERT, 32'h5555_5555, 32'h5A5A_5A5A, 1'b0, '0},
    '{OP_INSERT, 32'hAAAA_AAAA, 32'hC3C3_C3C3, 1'b0, '0},
    '{OP_INSERT, 32'h0000_0001, 32'h0000_0001, 1'b0, '0},
    '{OP_INSERT, 32'hFFFF_FFFE, 32'h8000_0000, 1'b0, '0},
    '{OP_FIND,   32'h5555_5555, 32'h0000_0000, 1'b0, '0},
    '{OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{OP_DELETE, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
    '{OP_INSERT, 32'h8000_0000, 32'h0F0F_0F0F, 1'b0, '0},
    '{OP_DELETE, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, '0},
    '{OP_SPARE,  32'h5555_5555, 32'h0000_0000, 1'b0, '0}
  };

  // Apply one request to the behavioural table and return the result it gives.
  // The lookup always runs first; an insert checks capacity before duplicates.
  function automatic table_reply_t apply_request(input logic [OP_W-1:0]    op,
                                                 input logic [KEY_W-1:0]   key,
                                                 input logic [VALUE_W-1:0] value);
    table_reply_t reply;
    int           below;
    int           hit_at;
    int           i;
    bit           hit;
    logic [VALUE_W-1:0] hit_value;
    reply     = '0;
    below     = 0;
    hit_at    = 0;
    hit       = 1'b0;
    hit_value = '0;
    for (i = 0; i < entry_count; i++) begin
      if (table_keys[i] < key) begin
        below++;
      end else if (table_keys[i] == key) begin
        hit       = 1'b1;
        hit_at    = i;
        hit_value = table_vals[i];
      end
    end
    if (op == OP_INSERT) begin
      if (entry_count >= DEPTH) begin
        reply.status = STS_FULL;
      end else if (hit) begin
        reply.status = STS_DUP;
      end else begin
        // open a slot at the insertion point
        for (i = entry_count; i > below; i--) begin
          table_keys[i] = table_keys[i-1];
          table_vals[i] = table_vals[i-1];
        end
        table_keys[below] = key;
        table_vals[below] = value;
        entry_count++;
        reply.status = STS_DONE;
      end
    end else if (op == OP_DELETE) begin
      if (hit) begin
        // close the gap left by the removed entry
        for (i = hit_at + 1; i < entry_count; i++) begin
          table_keys[i-1] = table_keys[i];
          table_vals[i-1] = table_vals[i];
        end
        entry_count--;
        reply.status = STS_DONE;
      end else begin
        reply.status = STS_MISS;
      end
    end else if (hit) begin
      reply.status = STS_DONE;
    end else begin
      reply.status = STS_MISS;
    end
    reply.found = hit;
    if (hit) begin
      reply.value    = hit_value;
      reply.position = POS_W'(hit_at);
    end
    reply.total = TOTAL_W'(entry_count);
    return reply;
  endfunction

  // Stored key (optionally nudged by one) when asked and possible, otherwise
  // a key biased towards the extremes and a small range.
  function automatic logic [KEY_W-1:0] pick_key(input bit stored);
    logic [KEY_W-1:0] key;
    if (stored && entry_count > 0) begin
      key = table_keys[$urandom_range(0, entry_count - 1)];
      case ($urandom_range(0, 7))
        0:       key = key + 1'b1;
        1:       key = key - 1'b1;
        default: ;
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0:       key = '0;
        1:       key = '1;
        2:       key = KEY_W'($urandom_range(0, 15));
        default: key = $urandom();
      endcase
    end
    return key;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Offer one request, hold it until taken, then queue the expected result.
  // Typed rows supply their own expectation; the behavioural table still advances.
  task automatic offer(input logic [OP_W-1:0]    op,
                       input logic [KEY_W-1:0]   key,
                       input logic [VALUE_W-1:0] value,
                       input bit                 typed = 1'b0,
                       input table_reply_t       want = '0);
    table_reply_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tdata  <= {{(IN_TDATA_W - OP_W - KEY_W - VALUE_W){1'b0}}, value, key, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = apply_request(op, key, value);
    pending_replies.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  // Result side: random stall bursts, one long hold-off that backs the table
  // up into its request port, and no stalls during the final stretch.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
      stall_left = 0;
    end else if (!long_hold_done && requests_sent >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      stall_left     = LONG_HOLD_LEN - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left     = $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin : result_check
    table_reply_t got;
    table_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.found    = m_axis_tdata[0];
      got.value    = m_axis_tdata[32:1];
      got.position = m_axis_tdata[38:33];
      got.status   = status_t'(m_axis_tdata[40:39]);
      got.total    = m_axis_tdata[47:41];
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: found=%0b value=%h position=%0d status=%0d total=%0d",
                   got.found, got.value, got.position, got.status, got.total);
      end else begin
        want = pending_replies.pop_front();
        if (got.found !== want.found || got.value !== want.value ||
            got.position !== want.position || got.status !== want.status ||
            got.total !== want.total) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected found=%0b value=%h position=%0d status=%0d total=%0d",
                     want.found, want.value, want.position, want.status, want.total);
            $display("          actual   found=%0b value=%h position=%0d status=%0d total=%0d",
                     got.found, got.value, got.position, got.status, got.total);
          end
        end
      end
    end
  end

  // Give up after a long stretch with no transaction on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int  phase;
    int  burst;
    int  target;
    int  r;
    bit  first;
    bit  settled;
    logic [OP_W-1:0] op;

    first   = 1'b1;
    settled = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (OPENING[n])
      offer(OPENING[n].op, OPENING[n].key, OPENING[n].value, OPENING[n].typed,
            OPENING[n].want);

    while (requests_sent < ITEM_TARGET) begin
      // once, let every outstanding result drain before carrying on
      if (!settled && requests_sent >= SETTLE_AT) begin
        settled = 1'b1;
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_replies.size() != 0);
      end
      phase = first ? 0 : $urandom_range(0, 9);
      first = 1'b0;
      case (phase)
        0, 1: begin
          // fill to capacity, then knock on the full table with new and stored keys
          while (entry_count < DEPTH) begin
            if ($urandom_range(0, 7) == 0)
              offer(OP_FIND, pick_key(1'b1), pick_value());
            else
              offer(OP_INSERT, pick_key(1'b0), pick_value());
          end
          repeat ($urandom_range(2, 5))
            offer(OP_INSERT, pick_key($urandom_range(0, 1)), pick_value());
        end
        2: begin
          // drain, sometimes to empty, with the odd stray delete
          target = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 8);
          while (entry_count > target) begin
            if ($urandom_range(0, 5) == 0)
              offer(OP_DELETE, pick_key(1'b0), pick_value());
            else
              offer(OP_DELETE, pick_key(1'b1), pick_value());
          end
          if (entry_count == 0) begin
            offer(OP_FIND, pick_key(1'b0), pick_value());
            offer(OP_DELETE, pick_key(1'b0), pick_value());
          end
        end
        default: begin
          // mixed traffic, mostly on stored keys and their neighbours
          burst = $urandom_range(20, 60);
          repeat (burst) begin
            r = $urandom_range(0, 19);
            if (r == 0)
              op = OP_SPARE;
            else if (r < 8)
              op = OP_FIND;
            else if (r < 14)
              op = OP_INSERT;
            else
              op = OP_DELETE;
            offer(op, pick_key($urandom_range(0, 2) != 0), pick_value());
          end
        end
      endcase
    end

    // drop valid, wait for the last results, then watch for strays
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
